### hdl/bpq_pkg.sv
`default_nettype none
package bpq_pkg;

	// Fixed field widths.
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 3;
	localparam int CAP_W    = 5;
	localparam int COUNT_W  = 5;

	// Default depth of the queue and reset value of the capacity register.
	localparam int MAX_ENTRIES_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Largest priority value that an enqueue may carry.
	localparam logic [PRIO_W-1:0] PRIO_TOP = 3'd5;

	// Data returned when no entry is removed.
	localparam logic signed [DATA_W-1:0] DATA_NONE = '1;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_BADPRIO = 2'd3
	} status_t;

	// One stored entry.
	typedef struct packed {
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} slot_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic  ins;
		logic  rem;
		slot_t new_slot;
	} cell_cmd_t;

endpackage
`default_nettype wire

### hdl/bpq_if.sv
`default_nettype none

// Request channel: one queue operation per transaction.
interface bpq_req_if;
	import bpq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [DATA_W-1:0] data_in;
	logic [PRIO_W-1:0]        priority_in;
	modport source (output valid, action, data_in, priority_in, input ready);
	modport sink (input valid, action, data_in, priority_in, output ready);
endinterface

// Response channel: one result per request.
interface bpq_rsp_if;
	import bpq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] data_out;
	logic [COUNT_W-1:0]       entry_count;
	modport source (output valid, status, data_out, entry_count, input ready);
	modport sink (input valid, status, data_out, entry_count, output ready);
endinterface

// Capacity register write channel.
interface bpq_cfg_if;
	import bpq_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### hdl/bpq_cell.sv
`default_nettype none
module bpq_cell
	import bpq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_cmd_t cmd,
	input  wire logic      slot_valid,
	input  wire slot_t     left_slot,
	input  wire logic      left_keep,
	input  wire slot_t     right_slot,
	output slot_t          slot,
	output logic           keep
);

	slot_t slot_q;

	// An occupied entry of equal or better priority stays ahead of a new one.
	assign keep = slot_valid && (slot_q.prio <= cmd.new_slot.prio);
	assign slot = slot_q;

	// Insert: hold, take the new entry at the boundary, or shift right.
	// Remove: shift left toward the head.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				slot_q <= left_keep ? cmd.new_slot : left_slot;
			end
		end else if (cmd.rem) begin
			slot_q <= right_slot;
		end
	end

endmodule
`default_nettype wire

### hdl/bounded_priority_queue_top.sv
// Bounded stable priority queue built as a sorted chain of cells.
// req carries one operation per transaction: action 0 enqueues data_in with
// priority_in (0 to 5, lower served first, equal priorities in arrival
// order), action 1 dequeues the head entry.
// rsp returns one result per request: status (ok, full, empty, bad
// priority), data_out (head data on a good dequeue, else all ones) and
// entry_count after the operation.
// cfg writes the capacity register; an enqueue reports full once the count
// reaches min(capacity, MAX_ENTRIES). Write it only while the queue is idle.
// Throughput is one request per cycle while rsp is not stalled: every cell
// compares against the new entry in parallel and the whole chain shifts in
// the cycle the request is taken. The response sits in an output register;
// a new request is taken while rsp is empty or is being taken, so a stalled
// receiver stalls req.
// Reset empties the queue and sets capacity to 16; cell contents are not
// cleared and are only read below the entry count.
`default_nettype none
module bounded_priority_queue_top
	import bpq_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bpq_req_if.sink   req,
	bpq_rsp_if.source rsp,
	bpq_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         cap_q;
	logic                     rsp_valid_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] data_out_q;
	logic [COUNT_W-1:0]       entry_count_q;

	logic             fire;
	logic             full;
	logic             bad_prio;
	logic             is_deq;
	logic             empty;
	cell_cmd_t        cmd;
	status_t          status_d;
	logic [CNT_W-1:0] count_d;

	slot_t slot_w [MAX_ENTRIES];
	logic  keep_w [MAX_ENTRIES];

	// Handshakes.
	assign cfg.ready = 1'b1;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	// Decode the request against the current count and capacity.
	assign is_deq   = (req.action == ACT_DEQ);
	assign empty    = (count_q == '0);
	assign full     = (LIM_W'(count_q) >= LIM_W'(cap_q))
	               || (count_q == CNT_W'(MAX_ENTRIES));
	assign bad_prio = (req.priority_in > PRIO_TOP);

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		priority if (is_deq) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				count_d = count_q - 1'b1;
			end
		end else if (full) begin
			status_d = ST_FULL;
		end else if (bad_prio) begin
			status_d = ST_BADPRIO;
		end else begin
			count_d = count_q + 1'b1;
		end
	end

	assign cmd.ins           = fire && !is_deq && (status_d == ST_OK);
	assign cmd.rem           = fire && is_deq && (status_d == ST_OK);
	assign cmd.new_slot.prio = req.priority_in;
	assign cmd.new_slot.data = req.data_in;

	// The chain of cells, head in cell 0.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		slot_t lslot;
		logic  lkeep;
		slot_t rslot;

		if (i == 0) begin : g_head
			assign lslot = '0;
			assign lkeep = 1'b1;
		end else begin : g_mid
			assign lslot = slot_w[i-1];
			assign lkeep = keep_w[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign rslot = '0;
		end else begin : g_body
			assign rslot = slot_w[i+1];
		end

		bpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.slot_valid (count_q > CNT_W'(i)),
			.left_slot  (lslot),
			.left_keep  (lkeep),
			.right_slot (rslot),
			.slot       (slot_w[i]),
			.keep       (keep_w[i])
		);
	end

	// Count and capacity registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			if (cfg.valid && cfg.ready) begin
				cap_q <= cfg.data;
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			data_out_q    <= cmd.rem ? slot_w[0].data : DATA_NONE;
			entry_count_q <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.data_out    = data_out_q;
	assign rsp.entry_count = entry_count_q;

`ifndef SYNTHESIS
	// The count never passes the depth of the chain.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count exceeds chain depth");

	// A rejected enqueue leaves the count unchanged.
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_deq && (full || bad_prio)) |=> (count_q == $past(count_q)))
		else $error("rejected enqueue changed the count");

	// A dequeue from a non-empty queue reports ok and lowers the count by one.
	a_deq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_deq && !empty) |=>
			(rsp.valid && rsp.status == ST_OK
			 && count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("dequeue result mismatch");
`endif

endmodule
`default_nettype wire
